// ===== rtl/core/msalu_pkg.sv =====
// Package with function codes, handshake types and helpers for the SPECIAL-group ALU.
package msalu_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned HLEN = 32;
  localparam int unsigned MODE_W = 6;
  localparam int unsigned SA_W = 5;
  localparam int unsigned ITER_W = 6;
  localparam logic [ITER_W-1:0] ITER_LAST = '1;

  localparam logic [MODE_W-1:0] FN_SLL     = 6'd0;
  localparam logic [MODE_W-1:0] FN_SRL     = 6'd2;
  localparam logic [MODE_W-1:0] FN_SRA     = 6'd3;
  localparam logic [MODE_W-1:0] FN_SLLV    = 6'd4;
  localparam logic [MODE_W-1:0] FN_SRLV    = 6'd6;
  localparam logic [MODE_W-1:0] FN_SRAV    = 6'd7;
  localparam logic [MODE_W-1:0] FN_SYSCALL = 6'd12;
  localparam logic [MODE_W-1:0] FN_MFHI    = 6'd16;
  localparam logic [MODE_W-1:0] FN_MTHI    = 6'd17;
  localparam logic [MODE_W-1:0] FN_MFLO    = 6'd18;
  localparam logic [MODE_W-1:0] FN_MTLO    = 6'd19;
  localparam logic [MODE_W-1:0] FN_DSLLV   = 6'd20;
  localparam logic [MODE_W-1:0] FN_DSRLV   = 6'd22;
  localparam logic [MODE_W-1:0] FN_DSRAV   = 6'd23;
  localparam logic [MODE_W-1:0] FN_MULT    = 6'd24;
  localparam logic [MODE_W-1:0] FN_MULTU   = 6'd25;
  localparam logic [MODE_W-1:0] FN_DIV     = 6'd26;
  localparam logic [MODE_W-1:0] FN_DIVU    = 6'd27;
  localparam logic [MODE_W-1:0] FN_DMULT   = 6'd28;
  localparam logic [MODE_W-1:0] FN_DMULTU  = 6'd29;
  localparam logic [MODE_W-1:0] FN_DDIV    = 6'd30;
  localparam logic [MODE_W-1:0] FN_DDIVU   = 6'd31;
  localparam logic [MODE_W-1:0] FN_ADD     = 6'd32;
  localparam logic [MODE_W-1:0] FN_ADDU    = 6'd33;
  localparam logic [MODE_W-1:0] FN_SUB     = 6'd34;
  localparam logic [MODE_W-1:0] FN_SUBU    = 6'd35;
  localparam logic [MODE_W-1:0] FN_AND     = 6'd36;
  localparam logic [MODE_W-1:0] FN_OR      = 6'd37;
  localparam logic [MODE_W-1:0] FN_XOR     = 6'd38;
  localparam logic [MODE_W-1:0] FN_NOR     = 6'd39;
  localparam logic [MODE_W-1:0] FN_SLT     = 6'd42;
  localparam logic [MODE_W-1:0] FN_SLTU    = 6'd43;
  localparam logic [MODE_W-1:0] FN_DADD    = 6'd44;
  localparam logic [MODE_W-1:0] FN_DADDU   = 6'd45;
  localparam logic [MODE_W-1:0] FN_DSUB    = 6'd46;
  localparam logic [MODE_W-1:0] FN_DSUBU   = 6'd47;
  localparam logic [MODE_W-1:0] FN_TEQ     = 6'd52;
  localparam logic [MODE_W-1:0] FN_DSLL    = 6'd56;
  localparam logic [MODE_W-1:0] FN_DSRL    = 6'd58;
  localparam logic [MODE_W-1:0] FN_DSRA    = 6'd59;
  localparam logic [MODE_W-1:0] FN_DSLL32  = 6'd60;
  localparam logic [MODE_W-1:0] FN_DSRL32  = 6'd62;
  localparam logic [MODE_W-1:0] FN_DSRA32  = 6'd63;

  // Multiply and divide codes share the upper three bits.
  localparam logic [2:0] FN_MULDIV_GRP = 3'b011;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic start_long;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_long;
  } status_t;

  function automatic logic [XLEN-1:0] sext32(input logic [HLEN-1:0] v);
    return {{(XLEN-HLEN){v[HLEN-1]}}, v};
  endfunction

endpackage

// ===== rtl/core/msalu_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface msalu_in_if;
  import msalu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [XLEN-1:0]   rs_value;
  logic signed [XLEN-1:0]   rt_value;
  logic [SA_W-1:0]          shift_amount;

  modport source (output valid, mode, rs_value, rt_value, shift_amount, input ready);
  modport sink (input valid, mode, rs_value, rt_value, shift_amount, output ready);
endinterface

interface msalu_out_if;
  import msalu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [XLEN-1:0]   rd_value;
  logic                     rd_write;
  logic                     trap_raised;
  logic                     syscall_raised;

  modport source (output valid, rd_value, rd_write, trap_raised, syscall_raised, input ready);
  modport sink (input valid, rd_value, rd_write, trap_raised, syscall_raised, output ready);
endinterface

// ===== rtl/core/msalu_dp.sv =====
// Datapath: combinational ALU, HI/LO registers, shared iterative multiply/divide, result register.
module msalu_dp
  import msalu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic [MODE_W-1:0]      mode,
  input  logic [XLEN-1:0]        rs,
  input  logic [XLEN-1:0]        rt,
  input  logic [SA_W-1:0]        sa,
  output logic [XLEN-1:0]        rd_value,
  output logic                   rd_write,
  output logic                   trap_raised,
  output logic                   syscall_raised
);

  logic [XLEN-1:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic [XLEN-1:0] acc_hi_r, acc_hi_nxt, acc_lo_r, acc_lo_nxt, opnd_r, opnd_nxt;
  logic            is_mul_r, is_32_r, neg_q_r, neg_r_r;
  logic [XLEN-1:0] rd_r;
  logic            wr_r, trap_r, sys_r;

  logic [XLEN-1:0] alu_rd;
  logic            alu_wr, alu_trap, alu_sys;
  logic [HLEN-1:0] rs32, rt32;
  logic [XLEN-1:0] rt_s32;

  // Operand preparation for the multiply/divide group.
  logic            md_signed, md_mul, md_32, div_zero;
  logic [XLEN-1:0] op_a, op_b, mag_a, mag_b;
  logic            neg_a, neg_b;

  // Iteration and finishing logic.
  logic [XLEN:0]     mul_sum;
  logic [XLEN-1:0]   mul_add;
  logic [XLEN:0]     div_t, div_diff;
  logic              div_ge;
  logic [2*XLEN-1:0] prod, prod_fix;
  logic [XLEN-1:0]   quo_fix, rem_fix, res_hi, res_lo;

  assign rs32   = rs[HLEN-1:0];
  assign rt32   = rt[HLEN-1:0];
  assign rt_s32 = sext32(rt32);

  assign md_signed = ~mode[0];
  assign md_mul    = ~mode[1];
  assign md_32     = ~mode[2];
  assign div_zero  = md_32 ? (rt32 == '0) : (rt == '0);
  assign op_a = md_32 ? (md_signed ? sext32(rs32) : {{(XLEN-HLEN){1'b0}}, rs32}) : rs;
  assign op_b = md_32 ? (md_signed ? rt_s32 : {{(XLEN-HLEN){1'b0}}, rt32}) : rt;
  assign neg_a = md_signed & op_a[XLEN-1];
  assign neg_b = md_signed & op_b[XLEN-1];
  assign mag_a = neg_a ? (~op_a + 1'b1) : op_a;
  assign mag_b = neg_b ? (~op_b + 1'b1) : op_b;
  assign status.is_long = (mode[MODE_W-1:3] == FN_MULDIV_GRP) && (md_mul || !div_zero);

  always_comb begin
    alu_rd   = '0;
    alu_wr   = 1'b1;
    alu_trap = 1'b0;
    alu_sys  = 1'b0;
    case (mode)
      FN_SLL:     alu_rd = sext32(rt32 << sa);
      FN_SRL:     alu_rd = sext32(rt32 >> sa);
      FN_SRA:     alu_rd = sext32($unsigned($signed(rt32) >>> sa));
      FN_SLLV:    alu_rd = sext32(rt32 << rs[4:0]);
      FN_SRLV:    alu_rd = sext32(rt32 >> rs[4:0]);
      FN_SRAV:    alu_rd = sext32($unsigned($signed(rt32) >>> rs[4:0]));
      FN_SYSCALL: begin
        alu_wr  = 1'b0;
        alu_sys = 1'b1;
      end
      FN_MFHI:    alu_rd = hi_r;
      FN_MFLO:    alu_rd = lo_r;
      FN_DSLLV:   alu_rd = rt << rs[5:0];
      FN_DSRLV:   alu_rd = rt >> rs[5:0];
      FN_DSRAV:   alu_rd = $unsigned($signed(rt) >>> rs[5:0]);
      FN_ADD, FN_ADDU: alu_rd = sext32(rs32 + rt32);
      FN_SUB, FN_SUBU: alu_rd = sext32(rs32 - rt32);
      FN_AND:     alu_rd = rs & rt;
      FN_OR:      alu_rd = rs | rt;
      FN_XOR:     alu_rd = rs ^ rt;
      FN_NOR:     alu_rd = ~(rs | rt);
      FN_SLT:     alu_rd = {{(XLEN-1){1'b0}}, ($signed(rs) < $signed(rt))};
      FN_SLTU:    alu_rd = {{(XLEN-1){1'b0}}, (rs < rt)};
      FN_DADD, FN_DADDU: alu_rd = rs + rt;
      FN_DSUB, FN_DSUBU: alu_rd = rs - rt;
      FN_TEQ: begin
        alu_wr   = 1'b0;
        alu_trap = (rs == rt);
      end
      FN_DSLL:    alu_rd = rt << sa;
      FN_DSRL:    alu_rd = rt >> sa;
      FN_DSRA:    alu_rd = $unsigned($signed(rt) >>> sa);
      FN_DSLL32:  alu_rd = rt << {1'b1, sa};
      FN_DSRL32:  alu_rd = rt >> {1'b1, sa};
      FN_DSRA32:  alu_rd = $unsigned($signed(rt) >>> {1'b1, sa});
      default:    alu_wr = 1'b0;
    endcase
    if (!alu_wr) begin
      alu_rd = '0;
    end
  end

  // One shift-add or one restoring-divide step per cycle on the shared accumulator.
  assign mul_add  = acc_lo_r[0] ? opnd_r : {XLEN{1'b0}};
  assign mul_sum  = {1'b0, acc_hi_r} + {1'b0, mul_add};
  assign div_t    = {acc_hi_r, acc_lo_r[XLEN-1]};
  assign div_diff = div_t - {1'b0, opnd_r};
  assign div_ge   = (div_t >= {1'b0, opnd_r});

  assign prod     = {acc_hi_r, acc_lo_r};
  assign prod_fix = neg_q_r ? (~prod + 1'b1) : prod;
  assign quo_fix  = neg_q_r ? (~acc_lo_r + 1'b1) : acc_lo_r;
  assign rem_fix  = neg_r_r ? (~acc_hi_r + 1'b1) : acc_hi_r;

  always_comb begin
    if (is_mul_r) begin
      res_hi = is_32_r ? sext32(prod_fix[XLEN-1:HLEN]) : prod_fix[2*XLEN-1:XLEN];
      res_lo = is_32_r ? sext32(prod_fix[HLEN-1:0]) : prod_fix[XLEN-1:0];
    end else begin
      res_hi = is_32_r ? sext32(rem_fix[HLEN-1:0]) : rem_fix;
      res_lo = is_32_r ? sext32(quo_fix[HLEN-1:0]) : quo_fix;
    end
  end

  always_comb begin
    acc_hi_nxt = acc_hi_r;
    acc_lo_nxt = acc_lo_r;
    opnd_nxt   = opnd_r;
    if (cmd.start_long) begin
      acc_hi_nxt = '0;
      acc_lo_nxt = md_mul ? mag_b : mag_a;
      opnd_nxt   = md_mul ? mag_a : mag_b;
    end else if (cmd.step) begin
      if (is_mul_r) begin
        acc_hi_nxt = mul_sum[XLEN:1];
        acc_lo_nxt = {mul_sum[0], acc_lo_r[XLEN-1:1]};
      end else begin
        acc_hi_nxt = div_ge ? div_diff[XLEN-1:0] : div_t[XLEN-1:0];
        acc_lo_nxt = {acc_lo_r[XLEN-2:0], div_ge};
      end
    end
  end

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    if (cmd.accept && mode == FN_MTHI) begin
      hi_nxt = rs;
    end
    if (cmd.accept && mode == FN_MTLO) begin
      lo_nxt = rs;
    end
    if (cmd.finish) begin
      hi_nxt = res_hi;
      lo_nxt = res_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_hi_r <= acc_hi_nxt;
    acc_lo_r <= acc_lo_nxt;
    opnd_r   <= opnd_nxt;
    if (cmd.start_long) begin
      is_mul_r <= md_mul;
      is_32_r  <= md_32;
      neg_q_r  <= neg_a ^ neg_b;
      neg_r_r  <= neg_a;
    end
    if (cmd.finish) begin
      rd_r   <= '0;
      wr_r   <= 1'b0;
      trap_r <= 1'b0;
      sys_r  <= 1'b0;
    end else if (cmd.accept && !cmd.start_long) begin
      rd_r   <= alu_rd;
      wr_r   <= alu_wr;
      trap_r <= alu_trap;
      sys_r  <= alu_sys;
    end
  end

  assign rd_value       = rd_r;
  assign rd_write       = wr_r;
  assign trap_raised    = trap_r;
  assign syscall_raised = sys_r;

endmodule

// ===== rtl/core/msalu_ctrl.sv =====
// Controller: handshakes, iteration count and sequencing of multiply/divide.
module msalu_ctrl
  import msalu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && out_free && status.is_long) state_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == ITER_LAST) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cnt_nxt        = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready       = out_free;
        cmd.accept     = in_valid && out_free;
        cmd.start_long = in_valid && out_free && status.is_long;
        cnt_nxt        = '0;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_FIN: cmd.finish = out_free;
      default: cmd = '0;
    endcase
    if ((cmd.accept && !cmd.start_long) || cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r == ITER_LAST) |=> state_r == ST_FIN)
    else $error("iteration did not end after the last step");

  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_long |=> (state_r == ST_RUN && cnt_r == '0))
    else $error("long operation did not start at step zero");

  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished operation produced no result");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input taken while multiply/divide busy");

endmodule

// ===== rtl/core/mips64_special_alu.sv =====
// Top level of the SPECIAL-group execute unit with HI/LO registers.
//
//  channel   dir  fields                                            transfer when
//  in_ch     in   mode, rs_value, rt_value, shift_amount            valid && ready
//  out_ch    out  rd_value, rd_write, trap_raised, syscall_raised   valid && ready
//
// Shifts, add/subtract, logic, compares, TEQ, SYSCALL and the HI/LO moves go straight
// through the ALU into the output register at the transfer.
// Multiply and divide run 64 iterations of the shared shift-add / restoring-divide
// accumulator plus a finishing state that does the sign fix and writes HI and LO.
// A divide by zero skips the unit and goes through like the ALU items above.
// Synchronous active-low reset clears HI, LO, the controller and the output valid flag.
// A new item transfers while the unit is idle and the result register is empty or
// being taken in the same cycle; a stalled output holds both result and input side.
module mips64_special_alu
  import msalu_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  msalu_in_if.sink   in_ch,
  msalu_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  // The controller owns every handshake decision; the datapath only follows commands.
  msalu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds HI/LO, the iteration accumulator and the result register.
  msalu_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .mode           (in_ch.mode),
    .rs             (in_ch.rs_value),
    .rt             (in_ch.rt_value),
    .sa             (in_ch.shift_amount),
    .rd_value       (out_ch.rd_value),
    .rd_write       (out_ch.rd_write),
    .trap_raised    (out_ch.trap_raised),
    .syscall_raised (out_ch.syscall_raised)
  );

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the SPECIAL-group execute unit with HI/LO registers.
module testbench
  import msalu_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [XLEN-1:0] rd_value;
    logic            rd_write;
    logic            trap_raised;
    logic            syscall_raised;
  } alu_result_t;

  localparam int unsigned IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  msalu_in_if  in_ch ();
  msalu_out_if out_ch ();

  mips64_special_alu uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // Shadow copy of the HI/LO pair, updated by the accepted instructions that write HI or LO.
  logic [XLEN-1:0] shadow_hi;
  logic [XLEN-1:0] shadow_lo;
  alu_result_t     pending_results[$];
  int unsigned     error_count = 0;
  int unsigned     sent_count = 0;
  int unsigned     checked_count = 0;
  int unsigned     idle_cycles = 0;
  bit              calm_phase = 1'b0;

  // Arithmetic right shift of a 64-bit value.
  function automatic logic [XLEN-1:0] shift_ar(input logic [XLEN-1:0] v, input int unsigned s);
    logic signed [XLEN-1:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  // Magnitude division with truncation toward zero; divisor must be nonzero.
  task automatic divide_signed(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                               output logic [XLEN-1:0] q, output logic [XLEN-1:0] r);
    logic [XLEN-1:0] ma, mb, uq, ur;
    ma = a[XLEN-1] ? -a : a;
    mb = b[XLEN-1] ? -b : b;
    uq = ma / mb;
    ur = ma % mb;
    q = (a[XLEN-1] != b[XLEN-1]) ? -uq : uq;
    r = a[XLEN-1] ? -ur : ur;
  endtask

  // Computes the result of one instruction and updates the shadow HI/LO pair.
  task automatic execute_special(input logic [MODE_W-1:0] fn, input logic [XLEN-1:0] rs,
                                 input logic [XLEN-1:0] rt, input logic [SA_W-1:0] sa,
                                 output alu_result_t res);
    logic [HLEN-1:0]   rs32, rt32;
    logic [XLEN-1:0]   q, r, p64;
    logic [2*XLEN-1:0] p128;
    logic              wr;
    rs32 = rs[HLEN-1:0];
    rt32 = rt[HLEN-1:0];
    res = '0;
    wr = 1'b1;
    case (fn)
      FN_SLL:     res.rd_value = sext32(rt32 << sa);
      FN_SRL:     res.rd_value = sext32(rt32 >> sa);
      FN_SRA:     res.rd_value = sext32($unsigned($signed(rt32) >>> sa));
      FN_SLLV:    res.rd_value = sext32(rt32 << rs32[4:0]);
      FN_SRLV:    res.rd_value = sext32(rt32 >> rs32[4:0]);
      FN_SRAV:    res.rd_value = sext32($unsigned($signed(rt32) >>> rs32[4:0]));
      FN_SYSCALL: begin
        wr = 1'b0;
        res.syscall_raised = 1'b1;
      end
      FN_MFHI:    res.rd_value = shadow_hi;
      FN_MTHI:    begin
        shadow_hi = rs;
        wr = 1'b0;
      end
      FN_MFLO:    res.rd_value = shadow_lo;
      FN_MTLO:    begin
        shadow_lo = rs;
        wr = 1'b0;
      end
      FN_DSLLV:   res.rd_value = rt << rs32[5:0];
      FN_DSRLV:   res.rd_value = rt >> rs32[5:0];
      FN_DSRAV:   res.rd_value = shift_ar(rt, rs32[5:0]);
      FN_MULT: begin
        p64 = sext32(rs32) * sext32(rt32);
        shadow_hi = sext32(p64[63:32]);
        shadow_lo = sext32(p64[31:0]);
        wr = 1'b0;
      end
      FN_MULTU: begin
        p64 = {32'd0, rs32} * {32'd0, rt32};
        shadow_hi = sext32(p64[63:32]);
        shadow_lo = sext32(p64[31:0]);
        wr = 1'b0;
      end
      FN_DIV: begin
        if (rt32 != 0) begin
          divide_signed(sext32(rs32), sext32(rt32), q, r);
          shadow_lo = sext32(q[31:0]);
          shadow_hi = sext32(r[31:0]);
        end
        wr = 1'b0;
      end
      FN_DIVU: begin
        if (rt32 != 0) begin
          shadow_lo = sext32(rs32 / rt32);
          shadow_hi = sext32(rs32 % rt32);
        end
        wr = 1'b0;
      end
      FN_DMULT: begin
        p128 = {{XLEN{rs[XLEN-1]}}, rs} * {{XLEN{rt[XLEN-1]}}, rt};
        shadow_hi = p128[127:64];
        shadow_lo = p128[63:0];
        wr = 1'b0;
      end
      FN_DMULTU: begin
        p128 = {{XLEN{1'b0}}, rs} * {{XLEN{1'b0}}, rt};
        shadow_hi = p128[127:64];
        shadow_lo = p128[63:0];
        wr = 1'b0;
      end
      FN_DDIV: begin
        if (rt != 0) begin
          divide_signed(rs, rt, q, r);
          shadow_lo = q;
          shadow_hi = r;
        end
        wr = 1'b0;
      end
      FN_DDIVU: begin
        if (rt != 0) begin
          shadow_lo = rs / rt;
          shadow_hi = rs % rt;
        end
        wr = 1'b0;
      end
      FN_ADD, FN_ADDU: res.rd_value = sext32(rs32 + rt32);
      FN_SUB, FN_SUBU: res.rd_value = sext32(rs32 - rt32);
      FN_AND:     res.rd_value = rs & rt;
      FN_OR:      res.rd_value = rs | rt;
      FN_XOR:     res.rd_value = rs ^ rt;
      FN_NOR:     res.rd_value = ~(rs | rt);
      FN_SLT:     res.rd_value = ($signed(rs) < $signed(rt)) ? 64'd1 : 64'd0;
      FN_SLTU:    res.rd_value = (rs < rt) ? 64'd1 : 64'd0;
      FN_DADD, FN_DADDU: res.rd_value = rs + rt;
      FN_DSUB, FN_DSUBU: res.rd_value = rs - rt;
      FN_TEQ: begin
        wr = 1'b0;
        res.trap_raised = (rs == rt);
      end
      FN_DSLL:    res.rd_value = rt << sa;
      FN_DSRL:    res.rd_value = rt >> sa;
      FN_DSRA:    res.rd_value = shift_ar(rt, sa);
      FN_DSLL32:  res.rd_value = rt << (32 + sa);
      FN_DSRL32:  res.rd_value = rt >> (32 + sa);
      FN_DSRA32:  res.rd_value = shift_ar(rt, 32 + sa);
      default:    wr = 1'b0;
    endcase
    if (!wr) begin
      res.rd_value = '0;
    end
    res.rd_write = wr;
  endtask

  // Random idle decision: a chance of about 7 in 100, none during the calm stretch.
  function automatic bit take_break();
    return !calm_phase && ($urandom_range(99) < 7);
  endfunction

  // Presents one instruction and holds it until the transfer happens.
  task automatic send_instruction(input logic [MODE_W-1:0] fn, input logic [XLEN-1:0] rs,
                                  input logic [XLEN-1:0] rt, input logic [SA_W-1:0] sa);
    alu_result_t res;
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= fn;
    in_ch.rs_value     <= rs;
    in_ch.rt_value     <= rt;
    in_ch.shift_amount <= sa;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    // The transfer happened at this edge, so the prediction is made in order.
    execute_special(fn, rs, rt, sa, res);
    pending_results.push_back(res);
    sent_count++;
  endtask

  // Operand with a bias toward boundary values.
  function automatic logic [XLEN-1:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return 64'h8000_0000_0000_0000;
      2: return '1;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return sext32($urandom);
      5: return {32'd0, $urandom};
      6: return {32'd0, $urandom_range(15)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // The result side: random stalls, and every transfer is checked in order.
  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result rd=%h", $time, out_ch.rd_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (out_ch.rd_value !== want.rd_value) begin
            $display("%0t: rd_value expected %h actual %h", $time, want.rd_value,
                     out_ch.rd_value);
            error_count++;
          end
          if (out_ch.rd_write !== want.rd_write) begin
            $display("%0t: rd_write expected %b actual %b", $time, want.rd_write,
                     out_ch.rd_write);
            error_count++;
          end
          if (out_ch.trap_raised !== want.trap_raised) begin
            $display("%0t: trap_raised expected %b actual %b", $time, want.trap_raised,
                     out_ch.trap_raised);
            error_count++;
          end
          if (out_ch.syscall_raised !== want.syscall_raised) begin
            $display("%0t: syscall_raised expected %b actual %b", $time,
                     want.syscall_raised, out_ch.syscall_raised);
            error_count++;
          end
        end
      end
      out_ch.ready <= !take_break();
    end
  end

  // Watchdog on cycles without any transfer; a multiply holds the input while it runs.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Directed extremes: all 64 codes, listed or not, once with boundary operands.
  task automatic test_directed_codes();
    logic [MODE_W-1:0] fn;
    for (int i = 0; i < 64; i++) begin
      fn = MODE_W'(i);
      send_instruction(fn, 64'h8000_0000_0000_0001, '1, 5'd31);
    end
  endtask

  // Special cases: HI/LO moves, division by zero, min over -1, TEQ, SYSCALL, shifts.
  task automatic test_special_cases();
    send_instruction(FN_MTHI, 64'h1234_5678_9abc_def0, 64'd0, 5'd0);
    send_instruction(FN_MTLO, 64'h0fed_cba9_8765_4321, 64'd0, 5'd0);
    send_instruction(FN_DIV, 64'd7, 64'hffff_ffff_0000_0000, 5'd0);
    send_instruction(FN_DDIV, 64'd7, 64'd0, 5'd0);
    send_instruction(FN_MFHI, 64'd0, 64'd0, 5'd0);
    send_instruction(FN_MFLO, 64'd0, 64'd0, 5'd0);
    send_instruction(FN_DIV, 64'h8000_0000, '1, 5'd0);
    send_instruction(FN_MFLO, 64'd0, 64'd0, 5'd0);
    send_instruction(FN_DDIV, 64'h8000_0000_0000_0000, '1, 5'd0);
    send_instruction(FN_MFHI, 64'd0, 64'd0, 5'd0);
    send_instruction(FN_DDIV, -64'sd7, 64'd2, 5'd0);
    send_instruction(FN_MFHI, 64'd0, 64'd0, 5'd0);
    send_instruction(FN_TEQ, 64'd5, 64'd5, 5'd0);
    send_instruction(FN_TEQ, 64'd5, 64'd6, 5'd0);
    send_instruction(FN_SYSCALL, 64'd0, 64'd0, 5'd0);
    send_instruction(FN_DSRAV, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 5'd0);
    send_instruction(FN_SRAV, 64'hffff_ffff_ffff_ffe0, 64'h8000_0000, 5'd0);
    send_instruction(FN_DSLL32, 64'd0, '1, 5'd0);
  endtask

  // Random traffic; multiply and divide are kept rare as each stalls the input side.
  task automatic test_random_traffic(input int unsigned count);
    logic [MODE_W-1:0] fn;
    for (int i = 0; i < count; i++) begin
      calm_phase = (i >= count / 2) && (i < count / 2 + 150);
      fn = MODE_W'($urandom_range(63));
      if (fn[5:3] == FN_MULDIV_GRP && $urandom_range(3) != 0) begin
        fn = ($urandom_range(1) != 0) ? FN_MFHI : FN_MFLO;
      end
      send_instruction(fn, pick_operand(), pick_operand(), SA_W'($urandom_range(31)));
    end
    calm_phase = 1'b0;
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= '0;
    in_ch.rs_value     <= '0;
    in_ch.rt_value     <= '0;
    in_ch.shift_amount <= '0;
    shadow_hi = '0;
    shadow_lo = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_codes();
    test_special_cases();
    test_random_traffic(1170);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (80) @(posedge clk);
    $display("Sent %0d instructions across all SPECIAL codes; %0d results checked.",
             sent_count, checked_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
